// File: src/lbbp_pkg.sv
package lbbp_pkg;

  // Channel count and PWM period
  localparam int CHANNELS_DEF     = 3;
  localparam int PWM_PERIOD_COUNT = 10000;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // Mode codes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_KEEP   = 2'd1;
  localparam logic [1:0] MODE_BLINK  = 2'd2;
  localparam logic [1:0] MODE_BREATH = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL = 3'd5;

  // Register reset values
  localparam logic [1:0] RST_MODE      = MODE_OFF;
  localparam logic [9:0] RST_ON_TICKS  = 10'd10;
  localparam logic [9:0] RST_OFF_TICKS = 10'd10;
  localparam logic [7:0] RST_PULSES    = 8'd2;
  localparam logic [7:0] RST_GAP       = 8'd20;
  localparam logic       RST_OFF_LEVEL = 1'b1;

  // Widths of the per-channel counters and the divider
  localparam int PHASE_W = 13;
  localparam int EDGE_W  = 9;
  localparam int BRTH_W  = 8;
  localparam int CNT_OUT_W = 14;
  localparam int DVD_W   = CNT_OUT_W + PHASE_W;
  localparam int DVS_W   = 10;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] channel;
  } lbbp_in_t;

  typedef struct packed {
    logic [1:0]           out_channel;
    logic                 pin_level;
    logic                 pwm_drive;
    logic                 duty_valid;
    logic [CNT_OUT_W-1:0] hi_cnt;
    logic [CNT_OUT_W-1:0] lo_cnt;
  } lbbp_out_t;

  typedef struct packed {
    logic capture;
    logic evaluate;
    logic div_step;
    logic emit;
  } lbbp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } lbbp_sts_t;

endpackage

// File: src/lbbp_ctrl.sv
module lbbp_ctrl
  import lbbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lbbp_sts_t sts_i,
  output lbbp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.evaluate = 1'b1;
        state_d        = sts_i.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the word
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/lbbp_dp.sv
module lbbp_dp
  import lbbp_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbbp_in_t             in_word_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lbbp_out_t            out_word_o,
  input  lbbp_cmd_t            cmd_i,
  output lbbp_sts_t            sts_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_OUT_W-1:0] PER = CNT_OUT_W'(PWM_PERIOD_COUNT);
  localparam logic [PHASE_W-1:0] PHASE_MAX = '1;
  localparam logic [BRTH_W-1:0]  BRTH_MAX  = '1;

  typedef enum logic [1:0] {
    BK_NONE,
    BK_RISE,
    BK_FALL,
    BK_DARK
  } duty_kind_e;

  // Configuration registers
  logic [1:0] mode_q;
  logic [9:0] on_q, off_q;
  logic [7:0] ppg_q, gap_q;
  logic       off_lvl_q;

  // Per-channel state
  logic [PHASE_W-1:0] phase_q  [CHANNELS];
  logic [EDGE_W-1:0]  edges_q  [CHANNELS];
  logic [BRTH_W-1:0]  brth_q   [CHANNELS];
  logic               lit_q    [CHANNELS];
  logic               run_q    [CHANNELS];

  // Captured item
  logic [1:0]       req_q, chan_q;
  logic             in_rng_q;
  logic [IDX_W-1:0] idx_q;

  // Pending result
  logic       pin_q, pwm_q;
  duty_kind_e kind_q, kind_d;

  // Divider
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Output register
  logic      out_valid_q;
  lbbp_out_t out_word_q, out_word_d;

  // Evaluation signals
  logic [PHASE_W-1:0] ph_cur, ph_d, ph_inc, n_brth;
  logic [EDGE_W-1:0]  ed_cur, ed_d, ed_group;
  logic [BRTH_W-1:0]  br_cur, br_d;
  logic               lit_cur, lit_d, run_cur, run_d;
  logic [PHASE_W:0]   ph_wide;
  logic [11:0]        gap_ticks, blink_len, cyc;
  logic [10:0]        two_on;
  logic [PHASE_W-1:0] cyc_gap;
  logic [PHASE_W-1:0] mult_op, mult_op_d;
  logic               pwm_d, pin_d;
  logic [CNT_OUT_W-1:0] quo_half;

  assign ph_cur  = phase_q[idx_q];
  assign ed_cur  = edges_q[idx_q];
  assign br_cur  = brth_q[idx_q];
  assign lit_cur = lit_q[idx_q];
  assign run_cur = run_q[idx_q];

  assign ph_wide   = {1'b0, ph_cur} + (PHASE_W+1)'(1);
  assign ph_inc    = ph_wide[PHASE_W] ? PHASE_MAX : ph_wide[PHASE_W-1:0];
  assign gap_ticks = 12'(gap_q) * 12'd10;
  assign ed_group  = {ppg_q, 1'b0};
  assign two_on    = {on_q, 1'b0};
  assign cyc       = 12'({on_q, 1'b0}) + 12'({off_q, 1'b0});
  assign cyc_gap   = PHASE_W'(cyc) + PHASE_W'(gap_ticks);
  assign blink_len = lit_cur ? 12'(on_q) : ((ed_cur == '0) ? gap_ticks : 12'(off_q));

  always_comb begin
    ph_d      = ph_cur;
    ed_d      = ed_cur;
    br_d      = br_cur;
    lit_d     = lit_cur;
    run_d     = run_cur;
    kind_d    = BK_NONE;
    mult_op_d = '0;
    dvs_d     = on_q;
    n_brth    = ph_inc;
    case (req_q)
      REQ_START: begin
        ph_d  = '0;
        ed_d  = ed_group;
        br_d  = '0;
        lit_d = (mode_q == MODE_KEEP) || (mode_q == MODE_BLINK);
        run_d = 1'b1;
      end
      REQ_STOP: begin
        ph_d  = '0;
        ed_d  = '0;
        br_d  = '0;
        lit_d = 1'b0;
        run_d = 1'b0;
      end
      REQ_TICK: begin
        if (run_cur && mode_q == MODE_BLINK) begin
          if (PHASE_W'(ph_inc) < PHASE_W'(blink_len)) begin
            ph_d = ph_inc;
          end else begin
            ph_d = '0;
            if (ed_cur == '0) begin
              lit_d = 1'b1;
              ed_d  = ed_group;
            end else if (ed_cur != EDGE_W'(1)) begin
              ed_d  = ed_cur - EDGE_W'(1);
              lit_d = ~lit_cur;
            end else if (gap_q != '0) begin
              lit_d = 1'b0;
              ed_d  = '0;
            end else begin
              lit_d = 1'b1;
              ed_d  = ed_group;
            end
          end
        end else if (run_cur && mode_q == MODE_BREATH && on_q != '0) begin
          if (ph_inc <= PHASE_W'(two_on)) begin
            kind_d    = BK_RISE;
            mult_op_d = ph_inc;
            dvs_d     = on_q;
          end else if (ph_inc <= PHASE_W'(cyc)) begin
            kind_d    = BK_FALL;
            mult_op_d = ph_inc - PHASE_W'(two_on);
            dvs_d     = off_q;
          end else if (br_cur < ppg_q) begin
            n_brth = '0;
          end else if (ph_inc <= cyc_gap) begin
            kind_d = BK_DARK;
          end else begin
            n_brth = '0;
            br_d   = '0;
          end
          // a breath ends exactly at the cycle length
          if (n_brth == PHASE_W'(cyc) && br_cur != BRTH_MAX) br_d = br_cur + BRTH_W'(1);
          ph_d = n_brth;
        end
      end
      default: ;
    endcase
  end

  assign mult_op = mult_op_d;
  assign pwm_d   = run_d && (mode_q == MODE_BREATH);
  assign pin_d   = (!pwm_d && lit_d) ? ~off_lvl_q : off_lvl_q;

  // Restoring divider, one quotient bit a cycle
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  assign quo_half = quo_q[CNT_OUT_W:1];

  always_comb begin
    out_word_d             = '0;
    out_word_d.out_channel = chan_q;
    out_word_d.pin_level   = in_rng_q ? pin_q : off_lvl_q;
    out_word_d.pwm_drive   = in_rng_q ? pwm_q : 1'b0;
    if (in_rng_q) begin
      case (kind_q)
        BK_RISE: begin
          out_word_d.duty_valid = 1'b1;
          out_word_d.hi_cnt     = quo_half;
          out_word_d.lo_cnt     = PER - quo_half;
        end
        BK_FALL: begin
          out_word_d.duty_valid = 1'b1;
          out_word_d.hi_cnt     = PER - quo_half;
          out_word_d.lo_cnt     = quo_half;
        end
        BK_DARK: begin
          out_word_d.duty_valid = 1'b1;
          out_word_d.hi_cnt     = '0;
          out_word_d.lo_cnt     = PER;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.need_div = in_rng_q && (kind_d == BK_RISE || kind_d == BK_FALL);
  assign sts_o.div_last = (cnt_q == CNT_W'(DVD_W - 1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= RST_MODE;
      on_q      <= RST_ON_TICKS;
      off_q     <= RST_OFF_TICKS;
      ppg_q     <= RST_PULSES;
      gap_q     <= RST_GAP;
      off_lvl_q <= RST_OFF_LEVEL;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:      mode_q    <= cfg_data_i[1:0];
        REG_ON_TICKS:  on_q      <= cfg_data_i[9:0];
        REG_OFF_TICKS: off_q     <= cfg_data_i[9:0];
        REG_PULSES:    ppg_q     <= cfg_data_i[7:0];
        REG_GAP:       gap_q     <= cfg_data_i[7:0];
        REG_OFF_LEVEL: off_lvl_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_q[i] <= '0;
        edges_q[i] <= '0;
        brth_q[i]  <= '0;
        lit_q[i]   <= 1'b0;
        run_q[i]   <= 1'b0;
      end
    end else if (cmd_i.evaluate && in_rng_q) begin
      phase_q[idx_q] <= ph_d;
      edges_q[idx_q] <= ed_d;
      brth_q[idx_q]  <= br_d;
      lit_q[idx_q]   <= lit_d;
      run_q[idx_q]   <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= in_word_i.req_type;
      chan_q   <= in_word_i.channel;
      in_rng_q <= int'(in_word_i.channel) < CHANNELS;
      idx_q    <= IDX_W'(in_word_i.channel);
    end
    if (cmd_i.evaluate) begin
      pin_q  <= pin_d;
      pwm_q  <= pwm_d;
      kind_q <= in_rng_q ? kind_d : BK_NONE;
      quo_q  <= DVD_W'(PER) * DVD_W'(mult_op);
      dvs_q  <= dvs_d;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.emit) out_word_q <= out_word_d;
  end

endmodule

// File: src/led_blink_breath_pattern_top.sv
// Channel  Direction  Handshake                Word
// input    in         in_valid_i / in_stall_o  in_word_i  (req_type, channel)
// output   out        out_valid_o / out_stall_i out_word_o (channel, pin, pwm, duty pair)
// config   in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// A breath tick that issues a ramp duty pair goes through capture, evaluate,
// 27 steps of the bit-serial restoring divider, then the output load.
// Every other word skips the divider. One word is worked on at a time.
// Reset clears all channel state and loads the register defaults.
// A stalled output holds the finished word; a new word is taken once the last is loaded.
module led_blink_breath_pattern_top
  import lbbp_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lbbp_in_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lbbp_out_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  lbbp_cmd_t cmd;
  lbbp_sts_t sts;

  lbbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbbp_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// File: tb/sv/tb_led_blink_breath_pattern_top.sv
`timescale 1ns / 1ps

module tb_led_blink_breath_pattern_top;
  import lbbp_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [1:0] CH_ABSENT = 2'd3;
  localparam int PHASES = 14;
  localparam int WORDS_PER_PHASE = 125;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  // A row either writes one register or sends one word; typed rows carry the
  // pin and PWM flags to expect, with no duty pair.
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    logic [1:0]           req;
    logic [1:0]           ch;
    logic                 typed;
    logic                 pin;
    logic                 pwm;
  } plan_row_t;

  localparam int PLAN_LEN = 43;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd0, 1'b1, 1'b1, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_START, 2'd1, 1'b1, 1'b1, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, CH_ABSENT, 1'b1, 1'b1, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_SPARE, 2'd1, 1'b1, 1'b1, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_START, CH_ABSENT, 1'b1, 1'b1, 1'b0},
    '{ROW_REG, REG_MODE, {8'd0, MODE_KEEP}, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_OFF_LEVEL, 10'd0, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_START, 2'd0, 1'b1, 1'b1, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd0, 1'b1, 1'b1, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_SPARE, 2'd1, 1'b1, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_STOP, 2'd0, 1'b1, 1'b0, 1'b0},
    '{ROW_REG, REG_MODE, {8'd0, MODE_BLINK}, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_ON_TICKS, 10'd0, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_OFF_TICKS, 10'd0, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_PULSES, 10'd0, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_GAP, 10'd0, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_START, 2'd2, 1'b1, 1'b1, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_ON_TICKS, 10'd1, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_OFF_TICKS, 10'd1, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_PULSES, 10'd1, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_START, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_GAP, 10'd1, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd2, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_MODE, {8'd0, MODE_BREATH}, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_ON_TICKS, 10'd0, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_START, 2'd0, 1'b1, 1'b0, 1'b1},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd0, 1'b1, 1'b0, 1'b1},
    '{ROW_REG, REG_ON_TICKS, 10'd1023, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_OFF_TICKS, 10'd1023, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_PULSES, 10'd255, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_REG, REG_GAP, 10'd255, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_STOP, 2'd0, 1'b1, 1'b0, 1'b0},
    '{ROW_REG, REG_OFF_LEVEL, 10'd1, REQ_TICK, 2'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WORD, REG_MODE, 10'd0, REQ_TICK, 2'd1, 1'b0, 1'b0, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  lbbp_in_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  lbbp_out_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  led_blink_breath_pattern_top #(
    .CHANNELS(CHANNELS_DEF)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_word_i(in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o(out_word),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  // Pattern registers as the block should hold them
  logic [1:0]  pat_mode = RST_MODE;
  int unsigned pat_on = 32'(RST_ON_TICKS);
  int unsigned pat_off = 32'(RST_OFF_TICKS);
  int unsigned pat_pulses = 32'(RST_PULSES);
  int unsigned pat_gap = 32'(RST_GAP);
  logic        pat_dark_lvl = RST_OFF_LEVEL;

  // Per-channel pattern state
  int unsigned ch_phase [CHANNELS_DEF];
  int unsigned ch_edges [CHANNELS_DEF];
  int unsigned ch_breaths [CHANNELS_DEF];
  bit          ch_lit [CHANNELS_DEF];
  bit          ch_run [CHANNELS_DEF];

  lbbp_out_t status_q [$];
  lbbp_out_t due;
  int        faults = 0;
  bit        quiet = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void clear_channel(int c);
    ch_phase[c] = 0;
    ch_edges[c] = 0;
    ch_breaths[c] = 0;
    ch_lit[c] = 1'b0;
    ch_run[c] = 1'b0;
  endfunction

  function automatic void blink_advance(int c);
    int unsigned len;
    int unsigned p;
    p = (ch_phase[c] + 1 > 8191) ? 8191 : ch_phase[c] + 1;
    if (ch_lit[c]) len = pat_on;
    else if (ch_edges[c] == 0) len = pat_gap * 10;
    else len = pat_off;
    if (p < len) begin
      ch_phase[c] = p;
      return;
    end
    ch_phase[c] = 0;
    if (ch_edges[c] == 0) begin
      ch_lit[c] = 1'b1;
      ch_edges[c] = 2 * pat_pulses;
    end else if (ch_edges[c] != 1) begin
      ch_edges[c] = ch_edges[c] - 1;
      ch_lit[c] = ~ch_lit[c];
    end else if (pat_gap != 0) begin
      ch_lit[c] = 1'b0;
      ch_edges[c] = 0;
    end else begin
      ch_lit[c] = 1'b1;
      ch_edges[c] = 2 * pat_pulses;
    end
  endfunction

  // Returns 1 when the tick issues a new high/low pair
  function automatic bit breath_advance(int c, output int unsigned hi, output int unsigned lo);
    int unsigned per;
    int unsigned cyc;
    int unsigned n;
    int unsigned h;
    int unsigned l;
    int unsigned d;
    per = PWM_PERIOD_COUNT;
    cyc = 2 * (pat_on + pat_off);
    h = 0;
    l = 0;
    hi = 0;
    lo = 0;
    if (pat_on == 0) return 1'b0;
    n = (ch_phase[c] + 1 > 8191) ? 8191 : ch_phase[c] + 1;
    if (n <= 2 * pat_on) begin
      h = per * n / pat_on / 2;
      l = per - h;
    end else if (n <= cyc) begin
      d = per * (n - 2 * pat_on) / pat_off / 2;
      h = per - d;
      l = d;
    end else if (ch_breaths[c] < pat_pulses) begin
      n = 0;
    end else if (n <= cyc + pat_gap * 10) begin
      h = 0;
      l = per;
    end else begin
      n = 0;
      ch_breaths[c] = 0;
    end
    if (n == cyc && ch_breaths[c] < 255) ch_breaths[c] = ch_breaths[c] + 1;
    ch_phase[c] = n;
    if (n == 0) return 1'b0;
    hi = h;
    lo = l;
    return 1'b1;
  endfunction

  function automatic lbbp_out_t next_led_status(lbbp_in_t w);
    lbbp_out_t   r;
    int          c;
    int unsigned hi;
    int unsigned lo;
    bit          pair;
    bit          pwm;
    c = int'(w.channel);
    r = '0;
    r.out_channel = w.channel;
    r.pin_level = pat_dark_lvl;
    pair = 1'b0;
    hi = 0;
    lo = 0;
    if (c >= CHANNELS_DEF) return r;
    case (w.req_type)
      REQ_START: begin
        clear_channel(c);
        ch_run[c] = 1'b1;
        ch_edges[c] = 2 * pat_pulses;
        ch_lit[c] = (pat_mode == MODE_KEEP || pat_mode == MODE_BLINK);
      end
      REQ_STOP: clear_channel(c);
      REQ_TICK: begin
        if (ch_run[c]) begin
          if (pat_mode == MODE_BLINK) blink_advance(c);
          else if (pat_mode == MODE_BREATH) pair = breath_advance(c, hi, lo);
        end
      end
      default: ;
    endcase
    pwm = ch_run[c] && pat_mode == MODE_BREATH;
    r.pwm_drive = pwm;
    r.pin_level = (!pwm && ch_lit[c]) ? ~pat_dark_lvl : pat_dark_lvl;
    if (pair) begin
      r.duty_valid = 1'b1;
      r.hi_cnt = hi[CNT_OUT_W-1:0];
      r.lo_cnt = lo[CNT_OUT_W-1:0];
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(lbbp_in_t w, bit typed, lbbp_out_t want);
    int        gap;
    lbbp_out_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    got = next_led_status(w);
    status_q.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // Write only once every expected word has come back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODE:      pat_mode = val[1:0];
      REG_ON_TICKS:  pat_on = 32'(val);
      REG_OFF_TICKS: pat_off = 32'(val);
      REG_PULSES:    pat_pulses = 32'(val[7:0]);
      REG_GAP:       pat_gap = 32'(val[7:0]);
      REG_OFF_LEVEL: pat_dark_lvl = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $error("word for channel %0d with none expected", out_word.out_channel);
        faults++;
      end else begin
        due = status_q.pop_front();
        compare_field("out_channel", 32'(due.out_channel), 32'(out_word.out_channel));
        compare_field("pin_level", 32'(due.pin_level), 32'(out_word.pin_level));
        compare_field("pwm_drive", 32'(due.pwm_drive), 32'(out_word.pwm_drive));
        compare_field("duty_valid", 32'(due.duty_valid), 32'(out_word.duty_valid));
        compare_field("hi_cnt", 32'(due.hi_cnt), 32'(out_word.hi_cnt));
        compare_field("lo_cnt", 32'(due.lo_cnt), 32'(out_word.lo_cnt));
      end
    end
  end

  // Receiver: free runs then stalls
  initial begin
    int n;
    forever begin
      @(negedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL led_blink_breath_pattern_top");
    $finish;
  end

  initial begin
    lbbp_in_t       w;
    lbbp_out_t      want;
    logic [1:0]     md;
    logic [9:0]     on_v;
    logic [9:0]     off_v;
    logic [7:0]     pulses_v;
    logic [7:0]     gap_v;
    int             r;
    for (int c = 0; c < CHANNELS_DEF; c++) clear_channel(c);
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_REG) begin
        write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
      end else begin
        w.req_type = PLAN[i].req;
        w.channel = PLAN[i].ch;
        want = '0;
        want.out_channel = PLAN[i].ch;
        want.pin_level = PLAN[i].pin;
        want.pwm_drive = PLAN[i].pwm;
        send_word(w, PLAN[i].typed, want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      r = $urandom_range(0, 9);
      md = (r < 4) ? MODE_BREATH : (r < 8) ? MODE_BLINK : (r < 9) ? MODE_KEEP : MODE_OFF;
      on_v = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                         : 10'($urandom_range(0, 4));
      off_v = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                          : 10'($urandom_range(0, 4));
      pulses_v = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 3));
      gap_v = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 2));
      // Hit both extremes of the on, off, pulse and gap registers once
      if (p == 4) begin
        on_v = 10'd1023;
        off_v = 10'd1023;
        pulses_v = 8'd255;
        gap_v = 8'd255;
      end else if (p == 5) begin
        md = MODE_BLINK;
        on_v = '0;
        off_v = '0;
        pulses_v = '0;
        gap_v = '0;
      end
      write_reg(REG_MODE, {8'd0, md});
      write_reg(REG_ON_TICKS, on_v);
      write_reg(REG_OFF_TICKS, off_v);
      write_reg(REG_PULSES, {2'd0, pulses_v});
      write_reg(REG_GAP, {2'd0, gap_v});
      write_reg(REG_OFF_LEVEL, 10'($urandom_range(0, 1)));

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        quiet = (p % 2 == 1) && k < 40;
        r = $urandom_range(0, 99);
        w.channel = 2'($urandom_range(0, CHANNELS_DEF - 1));
        w.req_type = REQ_TICK;
        if (r < 3) begin
          w.channel = CH_ABSENT;
          w.req_type = 2'($urandom_range(0, 3));
        end else if (r < 6) begin
          w.req_type = REQ_SPARE;
        end else if (r < 13) begin
          w.req_type = REQ_START;
        end else if (r < 16) begin
          w.req_type = REQ_STOP;
        end
        send_word(w, 1'b0, '0);
      end
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
    if (faults == 0) begin
      $display("PASS led_blink_breath_pattern_top");
    end else begin
      $display("FAIL led_blink_breath_pattern_top");
    end
    $finish;
  end

endmodule
